>>> hdl/ewfib_pkg.sv
`timescale 1ns / 1ps
// Package for the event window filter and image binner.
// It holds the image geometry, codes, shared types, the window check and the bin address helper.
// It has no dependencies.
package ewfib_pkg;

  // Image store geometry.
  localparam int unsigned IMG_COLS   = 512;
  localparam int unsigned IMG_ROWS   = 512;
  localparam int unsigned STORE_BINS = IMG_COLS * IMG_ROWS;
  localparam int unsigned IDX_W      = (STORE_BINS > 1) ? $clog2(STORE_BINS) : 1;
  localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(STORE_BINS - 1);
  localparam logic [15:0] COLS_W16 = 16'(IMG_COLS);
  localparam logic [15:0] ROWS_W16 = 16'(IMG_ROWS);

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 3;

  // Command codes.
  localparam logic CMD_BIN  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_WINDOW       = 3'd0,
    CFG_Y_WINDOW       = 3'd1,
    CFG_ENERGY_WINDOW  = 3'd2,
    CFG_TIME_WINDOW    = 3'd3,
    CFG_DET_WINDOW     = 3'd4,
    CFG_CHIP_RANGE     = 3'd5
  } cfg_idx_e;

  // Reject reasons, in check order.
  typedef enum logic [2:0] {
    RSN_NONE   = 3'd0,
    RSN_CHIP   = 3'd1,
    RSN_PIXEL  = 3'd2,
    RSN_ENERGY = 3'd3,
    RSN_TIME   = 3'd4,
    RSN_DET    = 3'd5
  } reason_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_e;

  // Configuration register file.
  typedef struct packed {
    logic [31:0] x_window;
    logic [31:0] y_window;
    logic [63:0] energy_window;
    logic [63:0] time_window;
    logic [63:0] det_window;
    logic [7:0]  chip_range;
  } cfg_t;

  // One incoming request.
  typedef struct packed {
    logic               command;
    logic [3:0]         chip_id;
    logic [15:0]        pixel_x;
    logic [15:0]        pixel_y;
    logic signed [31:0] energy;
    logic signed [31:0] arrival_time;
    logic signed [31:0] detector_energy;
    logic [8:0]         bin_col;
    logic [8:0]         bin_row;
  } item_t;

  // Filter verdict handed to the controller.
  typedef struct packed {
    logic             is_read;
    logic             do_mem;
    reason_e          reason;
    logic [IDX_W-1:0] index;
  } decision_t;

  // A value window with both bounds negative is off. Otherwise the lower bound
  // always applies and the upper bound applies only when it is not negative.
  function automatic logic window_fails(input logic [63:0] w,
                                        input logic signed [31:0] v);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic               fails;
    lo = signed'(w[31:0]);
    hi = signed'(w[63:32]);
    fails = 1'b0;
    if (!(lo[31] && hi[31])) begin
      if (v < lo) begin
        fails = 1'b1;
      end else if (!hi[31] && (v > hi)) begin
        fails = 1'b1;
      end
    end
    return fails;
  endfunction

  // Linear bin address: row-major order.
  function automatic logic [IDX_W-1:0] bin_index(input logic [15:0] row,
                                                 input logic [15:0] col);
    return IDX_W'(IDX_W'(row) * IDX_W'(IMG_COLS) + IDX_W'(col));
  endfunction

endpackage

>>> hdl/ewfib_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results of the image binner.
// Depends on nothing but the port widths fixed by the block.
interface ewfib_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [3:0]         chip_id;
  logic [15:0]        pixel_x;
  logic [15:0]        pixel_y;
  logic signed [31:0] energy;
  logic signed [31:0] arrival_time;
  logic signed [31:0] detector_energy;
  logic [8:0]         bin_col;
  logic [8:0]         bin_row;

  modport source (
    output valid, command, chip_id, pixel_x, pixel_y, energy, arrival_time,
           detector_energy, bin_col, bin_row,
    input  ready
  );
  modport sink (
    input  valid, command, chip_id, pixel_x, pixel_y, energy, arrival_time,
           detector_energy, bin_col, bin_row,
    output ready
  );
endinterface

interface ewfib_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [2:0]  reject_reason;
  logic [31:0] bin_count;
  logic [31:0] accepted_total;

  modport source (
    output valid, accepted, reject_reason, bin_count, accepted_total,
    input  ready
  );
  modport sink (
    input  valid, accepted, reject_reason, bin_count, accepted_total,
    output ready
  );
endinterface

>>> hdl/ewfib_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ewfib_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/ewfib_filter.sv
`timescale 1ns / 1ps
// Request filter: chip, pixel window and value window checks plus bin address.
// Depends on ewfib_pkg.
module ewfib_filter
  import ewfib_pkg::*;
(
  input  cfg_t      cfg_i,
  input  item_t     item_i,
  output decision_t dec_o
);

  logic [3:0]  chip_first;
  logic [3:0]  chip_last;
  logic [15:0] x0, x1, y0, y1;
  logic [15:0] dx, dy;
  logic        chip_bad;
  logic        pixel_bad;
  logic        read_in_range;
  reason_e     reason;

  assign chip_first = cfg_i.chip_range[3:0];
  assign chip_last  = cfg_i.chip_range[7:4];
  assign x0 = cfg_i.x_window[15:0];
  assign x1 = cfg_i.x_window[31:16];
  assign y0 = cfg_i.y_window[15:0];
  assign y1 = cfg_i.y_window[31:16];
  assign dx = item_i.pixel_x - x0;
  assign dy = item_i.pixel_y - y0;

  // Chip range and pixel window; the pixel must also land inside the store.
  assign chip_bad = (item_i.chip_id < chip_first) || (item_i.chip_id > chip_last);
  assign pixel_bad = (item_i.pixel_x < x0) || (item_i.pixel_x >= x1) ||
                     (item_i.pixel_y < y0) || (item_i.pixel_y >= y1) ||
                     (dx >= COLS_W16) || (dy >= ROWS_W16);

  assign read_in_range = ({7'd0, item_i.bin_col} < COLS_W16) &&
                         ({7'd0, item_i.bin_row} < ROWS_W16);

  // First failing check gives the reason.
  always_comb begin
    if (chip_bad) begin
      reason = RSN_CHIP;
    end else if (pixel_bad) begin
      reason = RSN_PIXEL;
    end else if (window_fails(cfg_i.energy_window, item_i.energy)) begin
      reason = RSN_ENERGY;
    end else if (window_fails(cfg_i.time_window, item_i.arrival_time)) begin
      reason = RSN_TIME;
    end else if (window_fails(cfg_i.det_window, item_i.detector_energy)) begin
      reason = RSN_DET;
    end else begin
      reason = RSN_NONE;
    end
  end

  // Verdict: a read touches memory when in range, an event when it passes.
  always_comb begin
    if (item_i.command == CMD_READ) begin
      dec_o.is_read = 1'b1;
      dec_o.do_mem  = read_in_range;
      dec_o.reason  = RSN_NONE;
      dec_o.index   = bin_index({7'd0, item_i.bin_row}, {7'd0, item_i.bin_col});
    end else begin
      dec_o.is_read = 1'b0;
      dec_o.do_mem  = (reason == RSN_NONE);
      dec_o.reason  = reason;
      dec_o.index   = bin_index(dy, dx);
    end
  end

endmodule

>>> hdl/event_window_filter_image_binner_top.sv
`timescale 1ns / 1ps
// Top level of the event window filter and image binner.
// Depends on ewfib_pkg, ewfib_if, ewfib_ram and ewfib_filter.

// Each request either bins one photon event or reads and clears one image bin,
// and yields exactly one result. After reset the block first sweeps the image
// memory to zero, one bin per cycle, through all IMG_COLS * IMG_ROWS bins;
// requests are held off during the sweep while configuration writes are taken.
// After that the accept cycle of a request issues the bin read, and the update
// state then writes the updated bin back and loads the result register. The
// update state is needed because the image memory has a registered read in the
// read-modify-write loop. A result waiting in the output register holds the
// write-back cycle, but a new request is taken as soon as it has moved there.
// Bin counts and the accepted total saturate at all ones. Configuration must
// only be written while no request is in flight.
module event_window_filter_image_binner_top
  import ewfib_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  ewfib_in_if.sink              in_req,
  ewfib_out_if.source           out_rsp
);

  state_e           state_q, state_d;
  cfg_t             cfg_q;
  item_t            item;
  decision_t        dec;
  decision_t        pend_q;
  logic [IDX_W-1:0] clr_addr_q, clr_addr_d;
  logic [31:0]      acc_q, acc_d;
  logic             in_fire;
  logic             out_free;
  logic             out_load;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic             ram_re;
  logic [31:0]      ram_rdata;
  logic [31:0]      bin_inc;
  logic [31:0]      count_d;
  logic             accepted_d;

  logic             out_valid_q;
  logic             out_accepted_q;
  reason_e          out_reason_q;
  logic [31:0]      out_count_q;
  logic [31:0]      out_total_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_window      <= '0;
      cfg_q.y_window      <= '0;
      cfg_q.energy_window <= '1;
      cfg_q.time_window   <= '1;
      cfg_q.det_window    <= '1;
      cfg_q.chip_range    <= 8'hF0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_X_WINDOW:      cfg_q.x_window      <= cfg_wdata_i[31:0];
        CFG_Y_WINDOW:      cfg_q.y_window      <= cfg_wdata_i[31:0];
        CFG_ENERGY_WINDOW: cfg_q.energy_window <= cfg_wdata_i;
        CFG_TIME_WINDOW:   cfg_q.time_window   <= cfg_wdata_i;
        CFG_DET_WINDOW:    cfg_q.det_window    <= cfg_wdata_i;
        CFG_CHIP_RANGE:    cfg_q.chip_range    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Gather the request payload.
  assign item.command         = in_req.command;
  assign item.chip_id         = in_req.chip_id;
  assign item.pixel_x         = in_req.pixel_x;
  assign item.pixel_y         = in_req.pixel_y;
  assign item.energy          = in_req.energy;
  assign item.arrival_time    = in_req.arrival_time;
  assign item.detector_energy = in_req.detector_energy;
  assign item.bin_col         = in_req.bin_col;
  assign item.bin_row         = in_req.bin_row;

  ewfib_filter u_filter (
    .cfg_i  (cfg_q),
    .item_i (item),
    .dec_o  (dec)
  );

  // Image memory.
  ewfib_ram #(
    .WIDTH (32),
    .DEPTH (STORE_BINS)
  ) u_image (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (dec.index),
    .rdata_o (ram_rdata)
  );

  assign in_fire  = in_req.valid && in_req.ready;
  assign out_free = !out_valid_q || out_rsp.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == LAST_BIN) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_req.ready = 1'b0;
    ram_re       = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = pend_q.index;
    ram_wdata    = '0;
    out_load     = 1'b0;
    clr_addr_d   = clr_addr_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        clr_addr_d = clr_addr_q + 1'b1;
      end
      ST_IDLE: begin
        in_req.ready = 1'b1;
        ram_re       = in_req.valid && dec.do_mem;
      end
      ST_UPDATE: begin
        if (out_free) begin
          out_load  = 1'b1;
          ram_we    = pend_q.do_mem;
          ram_wdata = pend_q.is_read ? 32'd0 : bin_inc;
        end
      end
      default: ;
    endcase
  end

  // Result of the read-modify-write.
  assign bin_inc    = (ram_rdata == '1) ? ram_rdata : ram_rdata + 32'd1;
  assign accepted_d = !pend_q.is_read && pend_q.do_mem;
  assign count_d    = !pend_q.do_mem ? 32'd0 : (pend_q.is_read ? ram_rdata : bin_inc);
  assign acc_d      = (accepted_d && (acc_q != '1)) ? acc_q + 32'd1 : acc_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      if (out_load) begin
        acc_q       <= acc_d;
        out_valid_q <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request verdict held across the memory read.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pend_q <= dec;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_accepted_q <= accepted_d;
      out_reason_q   <= pend_q.reason;
      out_count_q    <= count_d;
      out_total_q    <= acc_d;
    end
  end

  assign out_rsp.valid          = out_valid_q;
  assign out_rsp.accepted       = out_accepted_q;
  assign out_rsp.reject_reason  = out_reason_q;
  assign out_rsp.bin_count      = out_count_q;
  assign out_rsp.accepted_total = out_total_q;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the event window filter and image binner: sends bin and read requests,
// predicts every result with its own copy of the windows, image and total, and checks it.
// Depends on ewfib_pkg, the channel interfaces in ewfib_if and the top level.
module tb_top;
  import ewfib_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 2000000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HIT_LIST_MAX  = 64;
  localparam int unsigned RAND_PHASES   = 6;
  localparam int unsigned PHASE_ITEMS   = 100;

  // One predicted result.
  typedef struct packed {
    logic        accepted;
    reason_e     reason;
    logic [31:0] bin_count;
    logic [31:0] accepted_total;
  } bin_rsp_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  ewfib_in_if  req_if ();
  ewfib_out_if rsp_if ();

  event_window_filter_image_binner_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req      (req_if),
    .out_rsp     (rsp_if)
  );

  // Predictor state: window registers, sparse image and the accepted total.
  logic [31:0] x_win_q;
  logic [31:0] y_win_q;
  logic [63:0] energy_win_q;
  logic [63:0] time_win_q;
  logic [63:0] det_win_q;
  logic [7:0]  chip_rng_q;
  logic [31:0] image_bins [int unsigned];
  logic [31:0] kept_total;

  bin_rsp_t    pending_rsps [$];
  int unsigned hit_bins [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          pace_tx;
  bit          pace_rx;

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // A value window is off when both bounds are negative; the upper bound only
  // counts when it is not negative.
  function automatic logic value_rejected(input logic [63:0] win,
                                          input logic signed [31:0] value);
    logic signed [31:0] floor_v;
    logic signed [31:0] ceil_v;
    floor_v = win[31:0];
    ceil_v  = win[63:32];
    if (floor_v < 0 && ceil_v < 0) return 1'b0;
    return (value < floor_v) || (ceil_v >= 0 && value > ceil_v);
  endfunction

  // Applies one request to the predicted image and returns its result.
  function automatic bin_rsp_t predict_binning(input item_t req);
    bin_rsp_t    rsp;
    int unsigned col;
    int unsigned row;
    int unsigned idx;
    int unsigned x0, x1, y0, y1;
    logic [31:0] cnt;
    rsp = '0;
    rsp.reason = RSN_NONE;
    x0 = 32'(x_win_q[15:0]);
    x1 = 32'(x_win_q[31:16]);
    y0 = 32'(y_win_q[15:0]);
    y1 = 32'(y_win_q[31:16]);
    if (req.command == CMD_READ) begin
      col = 32'(req.bin_col);
      row = 32'(req.bin_row);
      if (col < IMG_COLS && row < IMG_ROWS) begin
        idx = row * IMG_COLS + col;
        if (image_bins.exists(idx)) begin
          rsp.bin_count = image_bins[idx];
          image_bins.delete(idx);
        end
      end
    end else begin
      if (req.chip_id < chip_rng_q[3:0] || req.chip_id > chip_rng_q[7:4]) begin
        rsp.reason = RSN_CHIP;
      end else if (req.pixel_x < x0 || req.pixel_x >= x1 || req.pixel_y < y0 ||
                   req.pixel_y >= y1 || req.pixel_x - x0 >= IMG_COLS ||
                   req.pixel_y - y0 >= IMG_ROWS) begin
        rsp.reason = RSN_PIXEL;
      end else if (value_rejected(energy_win_q, req.energy)) begin
        rsp.reason = RSN_ENERGY;
      end else if (value_rejected(time_win_q, req.arrival_time)) begin
        rsp.reason = RSN_TIME;
      end else if (value_rejected(det_win_q, req.detector_energy)) begin
        rsp.reason = RSN_DET;
      end
      if (rsp.reason == RSN_NONE) begin
        idx = (req.pixel_y - y0) * IMG_COLS + (req.pixel_x - x0);
        cnt = image_bins.exists(idx) ? image_bins[idx] : 32'd0;
        if (cnt != '1) cnt++;
        image_bins[idx] = cnt;
        rsp.bin_count = cnt;
        rsp.accepted = 1'b1;
        if (kept_total != '1) kept_total++;
        hit_bins.push_back(idx);
        if (hit_bins.size() > HIT_LIST_MAX) void'(hit_bins.pop_front());
      end
    end
    rsp.accepted_total = kept_total;
    return rsp;
  endfunction

  // Bin request; the read coordinates are ignored and left random.
  function automatic item_t event_item(input logic [3:0] chip, input logic [15:0] px,
                                       input logic [15:0] py, input logic [31:0] e,
                                       input logic [31:0] t, input logic [31:0] d);
    item_t req;
    req.command         = CMD_BIN;
    req.chip_id         = chip;
    req.pixel_x         = px;
    req.pixel_y         = py;
    req.energy          = e;
    req.arrival_time    = t;
    req.detector_energy = d;
    req.bin_col         = 9'($urandom);
    req.bin_row         = 9'($urandom);
    return req;
  endfunction

  // Read-and-clear request; the event fields are ignored and left random.
  function automatic item_t read_item(input logic [8:0] col, input logic [8:0] row);
    item_t req;
    req = event_item(4'($urandom), 16'($urandom), 16'($urandom), $urandom, $urandom,
                     $urandom);
    req.command = CMD_READ;
    req.bin_col = col;
    req.bin_row = row;
    return req;
  endfunction

  // Sends one request and records its predicted result once it is taken.
  task automatic send_request(input item_t req);
    int unsigned gap;
    gap = pace_tx ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.command         <= req.command;
    req_if.chip_id         <= req.chip_id;
    req_if.pixel_x         <= req.pixel_x;
    req_if.pixel_y         <= req.pixel_y;
    req_if.energy          <= req.energy;
    req_if.arrival_time    <= req.arrival_time;
    req_if.detector_energy <= req.detector_energy;
    req_if.bin_col         <= req.bin_col;
    req_if.bin_row         <= req.bin_row;
    do @(posedge clk_i); while (!req_if.ready);
    pending_rsps.push_back(predict_binning(req));
  endtask

  // Stops sending and waits until every predicted result has been checked.
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [63:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // Writes all six registers back to back, then mirrors them in the predictor.
  task automatic load_windows(input logic [31:0] xw, input logic [31:0] yw,
                              input logic [63:0] ew, input logic [63:0] tw,
                              input logic [63:0] dw, input logic [7:0] cr);
    put_reg(CFG_X_WINDOW, {32'h0, xw});
    put_reg(CFG_Y_WINDOW, {32'h0, yw});
    put_reg(CFG_ENERGY_WINDOW, ew);
    put_reg(CFG_TIME_WINDOW, tw);
    put_reg(CFG_DET_WINDOW, dw);
    put_reg(CFG_CHIP_RANGE, {56'h0, cr});
    cfg_we_i     <= 1'b0;
    x_win_q      = xw;
    y_win_q      = yw;
    energy_win_q = ew;
    time_win_q   = tw;
    det_win_q    = dw;
    chip_rng_q   = cr;
  endtask

  task automatic compare_field(input string what, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want_v, got_v);
      error_count++;
    end
  endtask

  // Result side: random stalls on ready, then each result against the oldest prediction.
  initial begin
    bin_rsp_t    want;
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = pace_rx ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      if (pending_rsps.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual accepted %0d reason %0d",
                 $time, rsp_if.accepted, rsp_if.reject_reason);
        error_count++;
      end else begin
        want = pending_rsps.pop_front();
        compare_field("accepted", 64'(want.accepted), 64'(rsp_if.accepted));
        compare_field("reject_reason", 64'(want.reason), 64'(rsp_if.reject_reason));
        compare_field("bin_count", 64'(want.bin_count), 64'(rsp_if.bin_count));
        compare_field("accepted_total", 64'(want.accepted_total),
                      64'(rsp_if.accepted_total));
      end
    end
  end

  // Reset values: the empty pixel window rejects every event, and bin 0 reads as zero.
  task automatic test_reset_defaults();
    send_request(event_item(4'd15, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h0, 32'h0));
    send_request(read_item(9'd0, 9'd0));
  endtask

  // One request per filter stage, and the check order when several fail.
  task automatic test_filter_checks();
    wait_for_results();
    load_windows({16'd616, 16'd16}, {16'd528, 16'd8}, {32'h0100_0000, 32'h0001_0000},
                 {32'hFFFF_FFFF, 32'h0}, {32'd1000, -32'sd1000}, 8'h92);
    send_request(event_item(4'd1, 16'd20, 16'd10, 32'h0002_0000, 32'd100, 32'd0));
    send_request(event_item(4'd10, 16'd20, 16'd10, 32'h0002_0000, 32'd100, 32'd0));
    send_request(event_item(4'd5, 16'd15, 16'd10, 32'h0002_0000, 32'd100, 32'd0));
    // Inside the window but past the last column of the image.
    send_request(event_item(4'd5, 16'd615, 16'd10, 32'h0002_0000, 32'd100, 32'd0));
    send_request(event_item(4'd5, 16'd20, 16'd528, 32'h0002_0000, 32'd100, 32'd0));
    send_request(event_item(4'd5, 16'd20, 16'd10, 32'h0000_FFFF, 32'd100, 32'd0));
    send_request(event_item(4'd5, 16'd20, 16'd10, 32'h0100_0001, 32'd100, 32'd0));
    send_request(event_item(4'd5, 16'd20, 16'd10, 32'h0002_0000, 32'hFFFF_FFFF, 32'd0));
    // Negative upper time bound: only the lower bound applies.
    send_request(event_item(4'd9, 16'd20, 16'd10, 32'h0100_0000, 32'h7FFF_FFFF, 32'd0));
    send_request(event_item(4'd5, 16'd20, 16'd10, 32'h0002_0000, 32'd100, -32'sd1001));
    send_request(event_item(4'd5, 16'd20, 16'd10, 32'h0002_0000, 32'd100, 32'd1001));
    send_request(event_item(4'd0, 16'd20, 16'd10, 32'h0, 32'hFFFF_FFFF, 32'd0));
  endtask

  // Back-to-back hits on one bin, the far corner, then read and clear.
  task automatic test_same_bin();
    pace_tx = 1'b0;
    repeat (3) send_request(event_item(4'd2, 16'd16, 16'd8, 32'h0002_0000, 32'd0, 32'd0));
    send_request(event_item(4'd9, 16'd527, 16'd519, 32'h0001_0000, 32'd5, -32'sd1000));
    send_request(read_item(9'd0, 9'd0));
    send_request(read_item(9'd0, 9'd0));
    send_request(read_item(9'd511, 9'd511));
    pace_tx = 1'b1;
  endtask

  // Extreme bounds: energy only at its maximum, time only at zero.
  task automatic test_window_extremes();
    wait_for_results();
    load_windows(32'hFFFF_0000, 32'hFFFF_0000, {32'hFFFF_FFFF, 32'h7FFF_FFFF},
                 64'h0, {32'h7FFF_FFFF, 32'h8000_0000}, 8'hF0);
    send_request(event_item(4'd0, 16'd0, 16'd0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000));
    send_request(event_item(4'd15, 16'hFFFF, 16'd0, 32'h7FFF_FFFF, 32'h0, 32'h0));
    send_request(event_item(4'd7, 16'd3, 16'd3, 32'h7FFF_FFFE, 32'h0, 32'h7FFF_FFFF));
    send_request(event_item(4'd7, 16'd3, 16'd3, 32'h8000_0000, 32'h0, 32'h0));
    send_request(event_item(4'd7, 16'd3, 16'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
  endtask

  // A chip range with first above last, then pixel windows with limit at or below start.
  task automatic test_inverted_ranges();
    wait_for_results();
    load_windows(32'hFFFF_0000, 32'hFFFF_0000, '1, '1, '1, 8'h3A);
    send_request(event_item(4'd12, 16'd10, 16'd10, 32'h0, 32'h0, 32'h0));
    wait_for_results();
    load_windows({16'd10, 16'd10}, {16'd5, 16'd20}, '1, '1, '1, 8'hF0);
    send_request(event_item(4'd5, 16'd10, 16'd10, 32'h0, 32'h0, 32'h0));
  endtask

  function automatic logic [31:0] rand_pixel_window();
    logic [15:0] start;
    logic [15:0] limit;
    int unsigned pick;
    int unsigned span;
    start = 16'($urandom);
    pick  = $urandom_range(0, 15);
    if (pick < 4) span = $urandom_range(1, 4);
    else if (pick < 11) span = $urandom_range(5, 512);
    else span = $urandom_range(513, 3000);
    if (pick == 15) limit = 16'($urandom_range(0, start));
    else limit = (start + span > 32'hFFFF) ? 16'hFFFF : 16'(start + span);
    return {limit, start};
  endfunction

  // Off, lower bound only, both bounds, or two non-negative bounds in any order.
  function automatic logic [63:0] rand_value_window();
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    int unsigned        mode;
    mode = $urandom_range(0, 9);
    if (mode < 3) begin
      lo = {1'b1, 31'($urandom)};
      hi = {1'b1, 31'($urandom)};
    end else if (mode < 5) begin
      lo = {1'b0, 31'($urandom)};
      hi = {1'b1, 31'($urandom)};
    end else if (mode < 9) begin
      hi = {1'b0, 31'($urandom)};
      lo = hi - $urandom_range(0, 32'h7FFF_FFFF);
    end else begin
      lo = {1'b0, 31'($urandom)};
      hi = {1'b0, 31'($urandom)};
    end
    return {hi, lo};
  endfunction

  // A value that the window lets through, if it lets any through, with its bounds drawn often.
  function automatic logic [31:0] rand_in_window(input logic [63:0] win);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    longint             base;
    longint             ceil;
    longint unsigned    draw;
    int unsigned        pick;
    lo = win[31:0];
    hi = win[63:32];
    if (lo < 0 && hi < 0) return $urandom;
    base = longint'(lo);
    ceil = (hi < 0) ? 64'sh7FFF_FFFF : longint'(hi);
    if (ceil < base) return $urandom;
    pick = $urandom_range(0, 7);
    if (pick == 0) return lo;
    if (pick == 1) return ceil[31:0];
    draw = {$urandom, $urandom};
    draw = draw % longint'(ceil - base + 1);
    return 32'(base + longint'(draw));
  endfunction

  function automatic logic [15:0] rand_in_span(input logic [31:0] win);
    if (win[31:16] <= win[15:0]) return 16'($urandom);
    return win[15:0] + 16'($urandom_range(0, win[31:16] - win[15:0] - 1));
  endfunction

  // Random settings per phase; mostly events drawn inside the windows, plus reads of
  // bins that were hit or random bins, repeats of the previous event and random noise.
  task automatic test_random_traffic();
    item_t       req;
    item_t       prev_evt;
    int unsigned kind;
    int unsigned idx;
    logic [3:0]  chip_first;
    logic [3:0]  chip_last;
    for (int unsigned phase = 0; phase < RAND_PHASES; phase++) begin
      wait_for_results();
      chip_first = 4'($urandom);
      chip_last  = ($urandom_range(0, 7) == 0) ? 4'($urandom) :
                   4'($urandom_range(chip_first, 15));
      load_windows(rand_pixel_window(), rand_pixel_window(), rand_value_window(),
                   rand_value_window(), rand_value_window(), {chip_last, chip_first});
      pace_tx = (phase % 3 != 0);
      pace_rx = (phase % 2 != 0);
      prev_evt = event_item(4'($urandom), 16'($urandom), 16'($urandom), $urandom,
                            $urandom, $urandom);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(0, 19);
        if (kind < 5) begin
          if (hit_bins.size() != 0 && $urandom_range(0, 3) != 0) begin
            idx = hit_bins[$urandom_range(0, hit_bins.size() - 1)];
            req = read_item(9'(idx % IMG_COLS), 9'(idx / IMG_COLS));
          end else begin
            req = read_item(9'($urandom), 9'($urandom));
          end
        end else if (kind < 7) begin
          req = event_item(4'($urandom), 16'($urandom), 16'($urandom), $urandom,
                           $urandom, $urandom);
        end else if (kind < 10) begin
          req = prev_evt;
        end else begin
          req = event_item(
            (chip_first <= chip_last) ? 4'($urandom_range(chip_first, chip_last)) :
                                        4'($urandom),
            rand_in_span(x_win_q), rand_in_span(y_win_q), rand_in_window(energy_win_q),
            rand_in_window(time_win_q), rand_in_window(det_win_q));
        end
        if (req.command == CMD_BIN) prev_evt = req;
        send_request(req);
        // Now and then hold off until the image binner has nothing in flight.
        if ($urandom_range(0, 59) == 0) wait_for_results();
      end
    end
  endtask

  // Reset, directed checks, random traffic, then the verdict.
  initial begin
    rst_ni                 <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_index_i            <= CFG_X_WINDOW;
    cfg_wdata_i            <= '0;
    req_if.valid           <= 1'b0;
    req_if.command         <= CMD_BIN;
    req_if.chip_id         <= '0;
    req_if.pixel_x         <= '0;
    req_if.pixel_y         <= '0;
    req_if.energy          <= '0;
    req_if.arrival_time    <= '0;
    req_if.detector_energy <= '0;
    req_if.bin_col         <= '0;
    req_if.bin_row         <= '0;
    pace_tx      = 1'b1;
    pace_rx      = 1'b1;
    x_win_q      = '0;
    y_win_q      = '0;
    energy_win_q = '1;
    time_win_q   = '1;
    det_win_q    = '1;
    chip_rng_q   = 8'hF0;
    kept_total   = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_filter_checks();
    test_same_bin();
    test_window_extremes();
    test_inverted_ranges();
    test_random_traffic();

    wait_for_results();
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && pending_rsps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
